// ===== src/sfcg_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcg_pkg
// Shared types and constants of the sinc FIR coefficient generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcg_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_TAPS_DEF   = 255;
  localparam int SINE_DEPTH_DEF = 1024;

  // Fixed-point constants.
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] INV_PI_Q32  = 64'd1367130551;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FILTER_MODE   = 3'd0;
  localparam logic [2:0] CFG_KERNEL_LENGTH = 3'd1;
  localparam logic [2:0] CFG_CUTOFF_SINGLE = 3'd2;
  localparam logic [2:0] CFG_CUTOFF_LOWER  = 3'd3;
  localparam logic [2:0] CFG_CUTOFF_UPPER  = 3'd4;

  // Filter response codes.
  typedef enum logic [1:0] {
    MODE_LOW_PASS    = 2'd0,
    MODE_HIGH_PASS   = 2'd1,
    MODE_BAND_PASS   = 2'd2,
    MODE_BAND_REJECT = 2'd3
  } filter_mode_e;

  // Register file contents.
  typedef struct packed {
    filter_mode_e mode;
    logic [7:0]   kernel_length;
    logic [16:0]  cutoff_single;
    logic [16:0]  cutoff_lower;
    logic [16:0]  cutoff_upper;
  } cfg_t;

  // Per-item control that travels down the pipeline.
  typedef struct packed {
    logic         valid;
    logic         outside;
    logic         is_center;
    filter_mode_e mode;
    logic [16:0]  cut_a;
    logic [16:0]  cut_b;
    logic [6:0]   ax;
  } tap_info_t;

endpackage

`default_nettype wire

// ===== src/sfcg_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sfcg_cfg_regs
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcg_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [16:0]   cfg_wdata_i,
  output sfcg_pkg::cfg_t     cfg_o
);
  import sfcg_pkg::*;

  cfg_t cfg_d, cfg_q;

  // Decode the write; an index beyond the register list is ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER_MODE:   cfg_d.mode          = filter_mode_e'(cfg_wdata_i[1:0]);
        CFG_KERNEL_LENGTH: cfg_d.kernel_length = cfg_wdata_i[7:0];
        CFG_CUTOFF_SINGLE: cfg_d.cutoff_single = cfg_wdata_i;
        CFG_CUTOFF_LOWER:  cfg_d.cutoff_lower  = cfg_wdata_i;
        CFG_CUTOFF_UPPER:  cfg_d.cutoff_upper  = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= MODE_LOW_PASS;
      cfg_q.kernel_length <= 8'd63;
      cfg_q.cutoff_single <= 17'd32768;
      cfg_q.cutoff_lower  <= 17'd8192;
      cfg_q.cutoff_upper  <= 17'd32768;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/sfcg_tap_phase.sv =====
// ----------------------------------------------------------------------------
// sfcg_tap_phase
// Tap decode, sine phase and quarter-wave table index (three stages).
// ----------------------------------------------------------------------------
`default_nettype none

module sfcg_tap_phase #(
  parameter int MAX_TAPS         = sfcg_pkg::MAX_TAPS_DEF,
  parameter int SINE_TABLE_DEPTH = sfcg_pkg::SINE_DEPTH_DEF,
  localparam int IdxW            = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [7:0]      tap_index_i,
  input  sfcg_pkg::cfg_t       cfg_i,
  output sfcg_pkg::tap_info_t  info_o,
  output logic [IdxW-1:0]      idx_a_o,
  output logic [IdxW-1:0]      idx_b_o,
  output logic                 neg_a_o,
  output logic                 neg_b_o
);
  import sfcg_pkg::*;

  localparam logic [7:0] LenCap  = (MAX_TAPS > 255) ? 8'd255 : 8'(MAX_TAPS);
  localparam int         PW      = 16 + IdxW;
  localparam logic [PW-1:0] DepthP = PW'(SINE_TABLE_DEPTH);
  localparam logic [PW-1:0] RoundP = PW'(16384);

  tap_info_t   s1_d, s1_q, s2_q, s3_q;
  logic [7:0]  len;
  logic [6:0]  half;
  logic [7:0]  ax_full;
  logic        is_band;
  logic [16:0] cut_single, cut_lower, cut_upper;
  logic [23:0] prod_a, prod_b;
  logic [16:0] phase_a_q, phase_b_q;
  logic [IdxW-1:0] idx_a_d, idx_b_d, idx_a_q, idx_b_q;
  logic        neg_a_q, neg_b_q;

  // Stage one: kernel half-length, offset from centre and cutoff choice.
  always_comb begin
    len        = (cfg_i.kernel_length > LenCap) ? LenCap : cfg_i.kernel_length;
    half       = (len == 8'd0) ? 7'd0 : 7'((len - 8'd1) >> 1);
    ax_full    = (tap_index_i >= {1'b0, half}) ? (tap_index_i - {1'b0, half})
                                               : ({1'b0, half} - tap_index_i);
    cut_single = (cfg_i.cutoff_single > ONE_Q16) ? ONE_Q16 : cfg_i.cutoff_single;
    cut_lower  = (cfg_i.cutoff_lower > ONE_Q16) ? ONE_Q16 : cfg_i.cutoff_lower;
    cut_upper  = (cfg_i.cutoff_upper > ONE_Q16) ? ONE_Q16 : cfg_i.cutoff_upper;
    is_band    = (cfg_i.mode == MODE_BAND_PASS) || (cfg_i.mode == MODE_BAND_REJECT);

    s1_d.valid     = start_i;
    s1_d.outside   = (len == 8'd0) || ({1'b0, tap_index_i} > {1'b0, half, 1'b0});
    s1_d.ax        = ax_full[6:0];
    s1_d.is_center = (ax_full == 8'd0);
    s1_d.mode      = cfg_i.mode;
    s1_d.cut_a     = is_band ? cut_upper : cut_single;
    s1_d.cut_b     = cut_lower;
  end

  // Stage two: phase fc*|x| in units of pi/65536, kept modulo two pi.
  assign prod_a = {7'd0, s1_q.cut_a} * {17'd0, s1_q.ax};
  assign prod_b = {7'd0, s1_q.cut_b} * {17'd0, s1_q.ax};

  // Stage three: nearest quarter-wave entry, mirrored in odd quadrants.
  function automatic logic [IdxW-1:0] table_idx(input logic [16:0] ph);
    logic [15:0]   qq;
    logic [PW-1:0] scaled;
    begin
      qq     = ph[15] ? (16'd32768 - {1'b0, ph[14:0]}) : {1'b0, ph[14:0]};
      scaled = ((PW'(qq) * DepthP) + RoundP) >> 15;
      if (scaled > DepthP) begin
        scaled = DepthP;
      end
      table_idx = scaled[IdxW-1:0];
    end
  endfunction

  assign idx_a_d = table_idx(phase_a_q);
  assign idx_b_d = table_idx(phase_b_q);

  // Stage registers; reset clears every stage, valid bits included.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      s2_q      <= '0;
      s3_q      <= '0;
      phase_a_q <= '0;
      phase_b_q <= '0;
      idx_a_q   <= '0;
      idx_b_q   <= '0;
      neg_a_q   <= 1'b0;
      neg_b_q   <= 1'b0;
    end else begin
      s1_q      <= s1_d;

      s2_q      <= s1_q;
      phase_a_q <= prod_a[16:0];
      phase_b_q <= prod_b[16:0];

      s3_q      <= s2_q;
      idx_a_q   <= idx_a_d;
      idx_b_q   <= idx_b_d;
      neg_a_q   <= phase_a_q[16];
      neg_b_q   <= phase_b_q[16];
    end
  end

  assign info_o  = s3_q;
  assign idx_a_o = idx_a_q;
  assign idx_b_o = idx_b_q;
  assign neg_a_o = neg_a_q;
  assign neg_b_o = neg_b_q;

endmodule

`default_nettype wire

// ===== src/sfcg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// sfcg_sine_rom
// Quarter-wave sine table in Q16 with two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcg_sine_rom #(
  parameter int  SINE_TABLE_DEPTH = sfcg_pkg::SINE_DEPTH_DEF,
  localparam int IdxW             = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic [IdxW-1:0] idx_a_i,
  input  wire logic [IdxW-1:0] idx_b_i,
  output logic [16:0]          sine_a_o,
  output logic [16:0]          sine_b_o
);
  import sfcg_pkg::*;

  // Series for sin(theta) with theta in Q30, each term truncated, then
  // rounded to Q16 and clamped to one.
  function automatic logic [16:0] sine_entry(input logic [63:0] theta);
    logic [63:0] th2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] v;
    begin
      th2  = (theta * theta) >> 30;
      term = theta;
      sum  = $signed(theta);
      term = ((term * th2) >> 30) / 64'd6;    sum = sum - $signed(term);
      term = ((term * th2) >> 30) / 64'd20;   sum = sum + $signed(term);
      term = ((term * th2) >> 30) / 64'd42;   sum = sum - $signed(term);
      term = ((term * th2) >> 30) / 64'd72;   sum = sum + $signed(term);
      term = ((term * th2) >> 30) / 64'd110;  sum = sum - $signed(term);
      term = ((term * th2) >> 30) / 64'd156;  sum = sum + $signed(term);
      term = ((term * th2) >> 30) / 64'd210;  sum = sum - $signed(term);
      if (sum < 0) begin
        sum = 64'sd0;
      end
      v = ($unsigned(sum) + 64'd8192) >> 14;
      if (v > 64'(ONE_Q16)) begin
        v = 64'(ONE_Q16);
      end
      sine_entry = v[16:0];
    end
  endfunction

  logic [16:0] sine_tab [SINE_TABLE_DEPTH + 1];
  logic [16:0] sine_a_q, sine_b_q;

  // Constant contents, one entry per step of the quarter wave.
  for (genvar Kk = 0; Kk <= SINE_TABLE_DEPTH; Kk++) begin : g_entry
    localparam logic [63:0] Theta = (HALF_PI_Q30 * 64'(Kk)) / 64'(SINE_TABLE_DEPTH);
    assign sine_tab[Kk] = sine_entry(Theta);
  end

  // Registered reads.
  always_ff @(posedge clk_i) begin
    sine_a_q <= sine_tab[idx_a_i];
    sine_b_q <= sine_tab[idx_b_i];
  end

  assign sine_a_o = sine_a_q;
  assign sine_b_o = sine_b_q;

endmodule

`default_nettype wire

// ===== src/sfcg_sinc_scale.sv =====
// ----------------------------------------------------------------------------
// sfcg_sinc_scale
// Scaling by 1/(pi*x), rounding, mode combination and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcg_sinc_scale #(
  parameter int MAX_TAPS = sfcg_pkg::MAX_TAPS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  sfcg_pkg::tap_info_t info_i,
  input  wire logic           neg_a_i,
  input  wire logic           neg_b_i,
  input  wire logic [16:0]    sine_a_i,
  input  wire logic [16:0]    sine_b_i,
  output logic                done_o,
  output logic signed [17:0]  coefficient_o,
  output logic                tap_outside_o
);
  import sfcg_pkg::*;

  localparam int RecipEntries = (MAX_TAPS - 1) / 2 + 1;
  localparam int RecipDepth   = (RecipEntries > 128) ? 128 : RecipEntries;
  localparam int RW           = $clog2(RecipDepth);
  localparam logic [7:0] RecipLim = 8'(RecipDepth);

  // Reciprocal table, entry n holds 1/(pi*n) in Q32.
  logic [30:0] recip_tab [RecipDepth];
  for (genvar Nn = 0; Nn < RecipDepth; Nn++) begin : g_recip
    localparam logic [63:0] Entry =
      (Nn == 0) ? 64'd0 : (INV_PI_Q32 + 64'(Nn / 2)) / 64'(Nn);
    assign recip_tab[Nn] = Entry[30:0];
  end

  tap_info_t   s4_q, s5_q, s6_q;
  logic [30:0] recip_d, recip_q;
  logic        neg_a4_q, neg_b4_q, neg_a5_q, neg_b5_q;
  logic [47:0] prod_a_q, prod_b_q;
  logic [47:0] rnd_a, rnd_b;
  logic signed [17:0] h_a_d, h_b_d, h_a_q, h_b_q;
  logic signed [19:0] wa, wb, delta, v;
  logic signed [17:0] coef_d, coef_q;
  logic        outside_q, done_q;

  // Stage four: reciprocal lookup beside the sine read.
  always_comb begin
    recip_d = 31'd0;
    if ({1'b0, info_i.ax} < RecipLim) begin
      recip_d = recip_tab[info_i.ax[RW-1:0]];
    end
  end

  // Stage six: round the Q48 product half up to Q16 and apply the sign;
  // the centre tap takes the cutoff itself.
  assign rnd_a = prod_a_q + 48'h0000_8000_0000;
  assign rnd_b = prod_b_q + 48'h0000_8000_0000;

  always_comb begin
    h_a_d = neg_a5_q ? -$signed({2'b00, rnd_a[47:32]}) : $signed({2'b00, rnd_a[47:32]});
    h_b_d = neg_b5_q ? -$signed({2'b00, rnd_b[47:32]}) : $signed({2'b00, rnd_b[47:32]});
    if (s5_q.is_center) begin
      h_a_d = $signed({1'b0, s5_q.cut_a});
      h_b_d = $signed({1'b0, s5_q.cut_b});
    end
  end

  // Stage seven: combine the sinc terms for the response, saturate, and zero taps outside the kernel.
  always_comb begin
    wa    = {{2{h_a_q[17]}}, h_a_q};
    wb    = {{2{h_b_q[17]}}, h_b_q};
    delta = s6_q.is_center ? 20'sd65536 : 20'sd0;
    unique case (s6_q.mode)
      MODE_LOW_PASS:    v = wa;
      MODE_HIGH_PASS:   v = delta - wa;
      MODE_BAND_PASS:   v = wa - wb;
      MODE_BAND_REJECT: v = delta - wa + wb;
      default:          v = wa;
    endcase
    if (v > 20'sd65536) begin
      coef_d = 18'sd65536;
    end else if (v < -20'sd65536) begin
      coef_d = -18'sd65536;
    end else begin
      coef_d = v[17:0];
    end
    if (s6_q.outside) begin
      coef_d = 18'sd0;
    end
  end

  // Stage registers; reset clears every stage, valid bits included.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q      <= '0;
      s5_q      <= '0;
      s6_q      <= '0;
      done_q    <= 1'b0;
      recip_q   <= '0;
      neg_a4_q  <= 1'b0;
      neg_b4_q  <= 1'b0;
      prod_a_q  <= '0;
      prod_b_q  <= '0;
      neg_a5_q  <= 1'b0;
      neg_b5_q  <= 1'b0;
      h_a_q     <= '0;
      h_b_q     <= '0;
      coef_q    <= '0;
      outside_q <= 1'b0;
    end else begin
      s4_q      <= info_i;
      recip_q   <= recip_d;
      neg_a4_q  <= neg_a_i;
      neg_b4_q  <= neg_b_i;

      s5_q      <= s4_q;
      prod_a_q  <= {31'd0, sine_a_i} * {17'd0, recip_q};
      prod_b_q  <= {31'd0, sine_b_i} * {17'd0, recip_q};
      neg_a5_q  <= neg_a4_q;
      neg_b5_q  <= neg_b4_q;

      s6_q      <= s5_q;
      h_a_q     <= h_a_d;
      h_b_q     <= h_b_d;

      done_q    <= s6_q.valid;
      coef_q    <= coef_d;
      outside_q <= s6_q.outside;
    end
  end

  assign done_o        = done_q;
  assign coefficient_o = coef_q;
  assign tap_outside_o = outside_q;

endmodule

`default_nettype wire

// ===== src/sinc_fir_coefficient_generator_unit.sv =====
// ----------------------------------------------------------------------------
// sinc_fir_coefficient_generator_unit
// Ideal sinc FIR kernel coefficients, one tap per item, in four responses.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  -------   ---------  ----------------------  -----------------------------
//  request   in         start_i, busy_o         tap_index_i
//  result    out        done_o (one cycle)      coefficient_o, tap_outside_o
//  config    in         cfg_we_i, cfg_idx_i     cfg_wdata_i
//
// A new item is taken in every cycle; busy_o stays low.
// Each result passes through the seven register stages in order: tap decode,
// phase product, table index, table read, reciprocal product, rounding and
// mode combination.
// Reset clears the valid bits of every stage and loads the register defaults.
// The receiver cannot stall, so the pipeline always advances.
// ----------------------------------------------------------------------------
`default_nettype none

module sinc_fir_coefficient_generator_unit #(
  parameter int  MAX_TAPS         = sfcg_pkg::MAX_TAPS_DEF,
  parameter int  SINE_TABLE_DEPTH = sfcg_pkg::SINE_DEPTH_DEF,
  localparam int IdxW             = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire logic [7:0]    tap_index_i,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [16:0]   cfg_wdata_i,
  output logic               done_o,
  output logic signed [17:0] coefficient_o,
  output logic               tap_outside_o
);
  import sfcg_pkg::*;

  cfg_t            cfg;
  tap_info_t       info;
  logic [IdxW-1:0] idx_a, idx_b;
  logic            neg_a, neg_b;
  logic [16:0]     sine_a, sine_b;
  logic            accept;

  // Items enter every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  sfcg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sfcg_tap_phase #(
    .MAX_TAPS         (MAX_TAPS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .tap_index_i (tap_index_i),
    .cfg_i       (cfg),
    .info_o      (info),
    .idx_a_o     (idx_a),
    .idx_b_o     (idx_b),
    .neg_a_o     (neg_a),
    .neg_b_o     (neg_b)
  );

  sfcg_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i    (clk_i),
    .idx_a_i  (idx_a),
    .idx_b_i  (idx_b),
    .sine_a_o (sine_a),
    .sine_b_o (sine_b)
  );

  sfcg_sinc_scale #(
    .MAX_TAPS (MAX_TAPS)
  ) u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .info_i        (info),
    .neg_a_i       (neg_a),
    .neg_b_i       (neg_b),
    .sine_a_i      (sine_a),
    .sine_b_i      (sine_b),
    .done_o        (done_o),
    .coefficient_o (coefficient_o),
    .tap_outside_o (tap_outside_o)
  );

endmodule

`default_nettype wire
